// ===== rtl/rotating_generation_key_set_top_assert.svh =====
// Assertion macros for the rotating generation key set.
`ifndef ROTATING_GENERATION_KEY_SET_TOP_ASSERT_SVH
`define ROTATING_GENERATION_KEY_SET_TOP_ASSERT_SVH
// Implication checked every clock outside reset.
`define RGKS_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define RGKS_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/rgks_pkg.sv =====
// Shared types and constants for the rotating generation key set.
`default_nettype none
package rgks_pkg;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_ENTRY_LIMIT = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_AGE     = 1'd1;
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_SCAN, ST_WRITE, ST_DONE
  } rgks_state_t;
endpackage
`default_nettype wire

// ===== rtl/rgks_entry_mem.sv =====
// Entry memory: hash, length/prefix and time, one synchronous read port.
`default_nettype none
module rgks_entry_mem #(
  parameter int unsigned AW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [63:0]   whash,
  input  wire logic [47:0]   wlp,
  input  wire logic [31:0]   wtime,
  input  wire logic [AW-1:0] raddr,
  output logic      [63:0]   rhash,
  output logic      [47:0]   rlp,
  output logic      [31:0]   rtime
);
  logic [143:0] mem [2**AW];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= {whash, wlp, wtime};
    {rhash, rlp, rtime} <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/rotating_generation_key_set_top.sv =====
// Top level of the rotating generation key set: sequencer around the entry memory.
// An insert scans the active generation up to a hash hit or its last entry, then writes and,
// on rotation, clears the new generation's valid bits; a lookup scans back from the active one.
// One item at a time, one memory read per entry scanned; the next beat is taken in the cycle
// after the result beat. Reset (rst_n low, synchronous) clears valid bits, counts,
// times and active index; entry limit returns to 63, age limit to 86400. No clearing pass.
`default_nettype none
`include "rotating_generation_key_set_top_assert.svh"
module rotating_generation_key_set_top
  import rgks_pkg::*;
#(
  parameter int unsigned MAP_COUNT = 4,
  parameter int unsigned GEN_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [63:0] in_key_hash,
  input  wire logic [15:0] in_key_length,
  input  wire logic [31:0] in_key_prefix,
  input  wire logic [31:0] in_now_seconds,
  input  wire logic [31:0] in_age_limit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_found,
  output logic             out_refreshed,
  output logic             out_rotated,
  output logic [1:0]       out_active_generation,
  output logic [6:0]       out_active_count
);
  localparam int unsigned GW = $clog2(MAP_COUNT);
  localparam int unsigned EW = $clog2(GEN_DEPTH);
  localparam int unsigned AW = GW + EW;
  localparam int unsigned CW = $clog2(GEN_DEPTH + 1);
  localparam logic [GW-1:0] GLAST = GW'(MAP_COUNT - 1);
  localparam logic [EW-1:0] ELAST = EW'(GEN_DEPTH - 1);

  rgks_state_t st_r, st_nxt;
  logic [5:0]  max_ent_r;
  logic [31:0] max_age_r;
  logic [2**AW-1:0] valid_r;
  logic [CW-1:0] cnt_r [MAP_COUNT];
  logic [31:0] created_r [MAP_COUNT];
  logic [31:0] lastw_r [MAP_COUNT];
  logic [GW-1:0] act_r;

  logic        mode_r;
  logic [63:0] hash_r;
  logic [47:0] lp_r;
  logic [31:0] now_r, age_r;
  logic [GW-1:0] g_r;        // generation under scan
  logic [GW-1:0] gsteps_r;   // generations done
  logic [EW-1:0] ridx_r;     // index issued to memory
  logic [EW-1:0] cidx_r;     // index whose data is back
  logic        rd_pend_r;
  logic        hit_r;
  logic [EW-1:0] hit_idx_r;
  logic        free_ok_r;
  logic [EW-1:0] free_idx_r;
  logic        found_r, refr_r, rot_r;
  logic [EW-1:0] clr_r;

  logic [63:0] m_hash;
  logic [47:0] m_lp;
  logic [31:0] m_time;
  logic        m_we;
  logic [AW-1:0] m_waddr, m_raddr;

  assign m_raddr = {g_r, ridx_r};
  assign m_we    = (st_r == ST_WRITE) && !hit_r ? free_ok_r
                 : (st_r == ST_WRITE);
  assign m_waddr = {g_r, hit_r ? hit_idx_r : free_idx_r};

  rgks_entry_mem #(.AW(AW)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr),
    .whash(hash_r), .wlp(lp_r), .wtime(now_r),
    .raddr(m_raddr), .rhash(m_hash), .rlp(m_lp), .rtime(m_time)
  );

  logic cur_valid, cur_hash_eq;
  assign cur_valid   = valid_r[{g_r, cidx_r}];
  assign cur_hash_eq = cur_valid && (m_hash == hash_r);

  logic [GW-1:0] g_prev, g_next;
  assign g_prev = (g_r == '0) ? GLAST : g_r - GW'(1);
  assign g_next = (g_r == GLAST) ? '0 : g_r + GW'(1);

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_DONE);
  assign out_found = found_r;
  assign out_refreshed = refr_r;
  assign out_rotated = rot_r;
  assign out_active_generation = 2'(act_r);
  assign out_active_count = 7'(cnt_r[act_r]);

  logic gen_skip;
  assign gen_skip = lastw_r[g_r] < age_r;

  logic res_stall;
  assign res_stall = out_valid && out_stall;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_valid) st_nxt = ST_SCAN;
      ST_SCAN:  begin
        if (mode_r == MODE_INSERT) begin
          if (rd_pend_r && (cur_hash_eq || cidx_r == ELAST)) st_nxt = ST_WRITE;
        end else if (rd_pend_r && cur_hash_eq) begin
          if (m_time >= age_r && m_lp == lp_r) st_nxt = ST_DONE;
          else if (gsteps_r == GLAST) st_nxt = ST_DONE;
        end else if ((rd_pend_r && cidx_r == ELAST) || (!rd_pend_r && gen_skip)) begin
          if (gsteps_r == GLAST) st_nxt = ST_DONE;
        end
      end
      ST_WRITE: st_nxt = ST_CLEAR;
      ST_CLEAR: if (!rot_r || clr_r == ELAST) st_nxt = ST_DONE;
      ST_DONE:  if (!out_stall) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  logic [CW-1:0] new_cnt;
  logic old_gen;
  assign new_cnt = cnt_r[g_r] + CW'(!hit_r && free_ok_r);
  assign old_gen = (now_r > created_r[g_r]) && ((now_r - created_r[g_r]) > max_age_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      max_ent_r <= 6'd63;
      max_age_r <= 32'd86400;
      valid_r <= '0;
      act_r <= '0;
      rd_pend_r <= 1'b0;
      for (int i = 0; i < MAP_COUNT; i++) begin
        cnt_r[i] <= '0; created_r[i] <= '0; lastw_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_ENTRY_LIMIT) max_ent_r <= cfg_data[5:0];
        else if (cfg_index == REG_MAX_AGE) max_age_r <= cfg_data;
      end
      unique case (st_r)
        ST_IDLE: begin
          mode_r <= in_mode; hash_r <= in_key_hash;
          lp_r <= {in_key_length, in_key_prefix};
          now_r <= in_now_seconds; age_r <= in_age_limit;
          g_r <= act_r; gsteps_r <= '0; ridx_r <= '0; rd_pend_r <= 1'b0;
          hit_r <= 1'b0; free_ok_r <= 1'b0; found_r <= 1'b0;
          refr_r <= 1'b0; rot_r <= 1'b0; clr_r <= '0;
        end
        ST_SCAN: begin
          if (mode_r == MODE_LOOKUP && !rd_pend_r && gen_skip) begin
            // skip a generation last written before the age limit
            g_r <= g_prev; gsteps_r <= gsteps_r + GW'(1);
          end else if (mode_r == MODE_LOOKUP && rd_pend_r && (cur_hash_eq || cidx_r == ELAST)) begin
            // hash seen or generation done: move on to the next older one
            found_r <= cur_hash_eq && (m_time >= age_r) && (m_lp == lp_r);
            rd_pend_r <= 1'b0; ridx_r <= '0;
            g_r <= g_prev; gsteps_r <= gsteps_r + GW'(1);
          end else begin
            // advance the read pointer; data for ridx_r returns next cycle
            rd_pend_r <= 1'b1;
            cidx_r <= ridx_r;
            ridx_r <= ridx_r + EW'(1);
            if (rd_pend_r) begin
              if (!cur_valid && !free_ok_r) begin
                free_ok_r <= 1'b1; free_idx_r <= cidx_r;
              end
              if (cur_hash_eq) begin
                hit_r <= 1'b1; hit_idx_r <= cidx_r;
                refr_r <= (m_lp == lp_r);
              end
            end
          end
        end
        ST_WRITE: begin
          lastw_r[g_r] <= now_r;
          if (!refr_r) begin
            if (!hit_r && free_ok_r) valid_r[{g_r, free_idx_r}] <= 1'b1;
            cnt_r[g_r] <= new_cnt;
            if ((new_cnt > CW'(max_ent_r)) || old_gen || (new_cnt >= CW'(GEN_DEPTH))) begin
              rot_r <= 1'b1;
              act_r <= g_next;
              g_r   <= g_next;
            end
          end
        end
        ST_CLEAR: begin
          if (rot_r) begin
            valid_r[{g_r, clr_r}] <= 1'b0;
            clr_r <= clr_r + EW'(1);
            cnt_r[g_r] <= '0; created_r[g_r] <= now_r; lastw_r[g_r] <= now_r;
          end
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  `RGKS_ASSERT_IMP(a_stall_busy, clk, rst_n, out_valid, in_stall, "input taken while busy")
  `RGKS_ASSERT_IMP(a_excl, clk, rst_n, out_found, !out_refreshed && !out_rotated, "flags mixed")
  `RGKS_ASSERT_NXT(a_hold, clk, rst_n, res_stall, $stable({out_valid, out_found}), "beat dropped")
  `RGKS_ASSERT_IMP(a_rot_nref, clk, rst_n, out_rotated, !out_refreshed, "refresh rotated")
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the rotating generation key set top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import rgks_pkg::*;

  localparam int unsigned GENS  = 4;
  localparam int unsigned DEPTH = 64;
  localparam int unsigned DRAIN = 400;

  typedef struct packed {
    logic        mode;
    logic [63:0] hash;
    logic [15:0] len;
    logic [31:0] prefix;
    logic [31:0] now;
    logic [31:0] age;
  } key_op_t;

  typedef struct packed {
    logic       found;
    logic       refreshed;
    logic       rotated;
    logic [1:0] gen;
    logic [6:0] count;
  } set_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = REG_ENTRY_LIMIT;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = MODE_INSERT;
  logic [63:0] in_key_hash = '0;
  logic [15:0] in_key_length = '0;
  logic [31:0] in_key_prefix = '0;
  logic [31:0] in_now_seconds = '0;
  logic [31:0] in_age_limit = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_found, out_refreshed, out_rotated;
  logic [1:0] out_active_generation;
  logic [6:0] out_active_count;

  rotating_generation_key_set_top u_dut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_mode, .in_key_hash, .in_key_length, .in_key_prefix,
    .in_now_seconds, .in_age_limit,
    .out_valid, .out_stall, .out_found, .out_refreshed, .out_rotated,
    .out_active_generation, .out_active_count
  );

  // Shadow copy of the key store.
  logic [63:0] sh_hash [GENS*DEPTH];
  logic [47:0] sh_lp   [GENS*DEPTH];
  logic [31:0] sh_time [GENS*DEPTH];
  bit          sh_valid[GENS*DEPTH];
  int unsigned gen_count[GENS];
  logic [31:0] gen_created[GENS];
  logic [31:0] gen_last[GENS];
  int unsigned active_gen = 0;
  logic [5:0]  lim_entries = 6'd63;
  logic [31:0] lim_age = 32'd86400;

  key_op_t     op_queue[$];
  set_status_t status_queue[$];
  key_op_t     cur_op;
  int errors = 0;
  int n_checked = 0, n_hits = 0, n_refresh = 0, n_rotate = 0, n_full = 0;
  bit idle_on = 1'b1;
  bit hold_done = 1'b0;
  int send_gap = 0, recv_gap = 0, hold_cycles = 0;

  logic [63:0] hash_pool[96];
  logic [47:0] lp_pool[96];
  logic [31:0] clock_s = 32'd1000;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("[rotating_generation_key_set_top] ERROR");
    $finish;
  end

  function automatic int find_entry(int unsigned g, logic [63:0] h);
    for (int i = 0; i < DEPTH; i++)
      if (sh_valid[g*DEPTH+i] && sh_hash[g*DEPTH+i] == h) return g*DEPTH + i;
    return -1;
  endfunction

  function automatic set_status_t predict_status(key_op_t k);
    set_status_t r;
    logic [47:0] lp;
    int p;
    int unsigned g;
    bit stale;
    r = '0;
    lp = {k.len, k.prefix};
    if (k.mode == MODE_LOOKUP) begin
      for (int i = 0; i < GENS && !r.found; i++) begin
        g = (active_gen + GENS - i) % GENS;
        if (gen_last[g] < k.age) continue;
        p = find_entry(g, k.hash);
        if (p < 0) continue;
        if (sh_time[p] < k.age || sh_lp[p] != lp) continue;
        r.found = 1'b1;
      end
      if (r.found) n_hits++;
    end else begin
      p = find_entry(active_gen, k.hash);
      if (p >= 0 && sh_lp[p] == lp) begin
        sh_time[p] = k.now;
        gen_last[active_gen] = k.now;
        r.refreshed = 1'b1;
        n_refresh++;
      end else begin
        if (p < 0) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (!sh_valid[active_gen*DEPTH+i]) begin
              p = active_gen*DEPTH + i;
              sh_valid[p] = 1'b1;
              gen_count[active_gen]++;
              break;
            end
          end
        end
        if (p >= 0) begin
          sh_hash[p] = k.hash;
          sh_lp[p] = lp;
          sh_time[p] = k.now;
        end
        gen_last[active_gen] = k.now;
        stale = k.now > gen_created[active_gen] && (k.now - gen_created[active_gen]) > lim_age;
        if (gen_count[active_gen] >= DEPTH) n_full++;
        if (gen_count[active_gen] > lim_entries || stale || gen_count[active_gen] >= DEPTH) begin
          active_gen = (active_gen + 1) % GENS;
          for (int i = 0; i < DEPTH; i++) sh_valid[active_gen*DEPTH+i] = 1'b0;
          gen_count[active_gen] = 0;
          gen_created[active_gen] = k.now;
          gen_last[active_gen] = k.now;
          r.rotated = 1'b1;
          n_rotate++;
        end
      end
    end
    r.gen = active_gen[1:0];
    r.count = gen_count[active_gen][6:0];
    return r;
  endfunction

  // Sender: predict on each accepted beat, then hold, gap or offer the next item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) status_queue.push_back(predict_status(cur_op));
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (op_queue.size() > 0) begin
        cur_op = op_queue.pop_front();
        in_mode <= cur_op.mode;
        in_key_hash <= cur_op.hash;
        in_key_length <= cur_op.len;
        in_key_prefix <= cur_op.prefix;
        in_now_seconds <= cur_op.now;
        in_age_limit <= cur_op.age;
        in_valid <= 1'b1;
        send_gap = idle_on ? $urandom_range(0, 9) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: compare each result beat, then draw the stall for the next one.
  always @(posedge clk) begin
    set_status_t exp_s;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (status_queue.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          exp_s = status_queue.pop_front();
          if (out_found !== exp_s.found) begin
            $error("found: expected %0d, got %0d", exp_s.found, out_found); errors++;
          end
          if (out_refreshed !== exp_s.refreshed) begin
            $error("refreshed: expected %0d, got %0d", exp_s.refreshed, out_refreshed); errors++;
          end
          if (out_rotated !== exp_s.rotated) begin
            $error("rotated: expected %0d, got %0d", exp_s.rotated, out_rotated); errors++;
          end
          if (out_active_generation !== exp_s.gen) begin
            $error("active_generation: expected %0d, got %0d", exp_s.gen,
                   out_active_generation); errors++;
          end
          if (out_active_count !== exp_s.count) begin
            $error("active_count: expected %0d, got %0d", exp_s.count, out_active_count);
            errors++;
          end
        end
        recv_gap = idle_on ? $urandom_range(0, 9) : 0;
        if (n_checked == 300 && !hold_done) begin
          hold_done = 1'b1;
          hold_cycles = 1500;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_op(logic mode, logic [63:0] h, logic [15:0] l, logic [31:0] p,
                         logic [31:0] n, logic [31:0] a);
    key_op_t k;
    k = '{mode: mode, hash: h, len: l, prefix: p, now: n, age: a};
    op_queue.push_back(k);
  endtask

  // Mostly pooled keys on a slowly advancing clock; some noise, jumps and clock steps back.
  task automatic push_random(int count);
    int idx, pick;
    logic [47:0] lp;
    logic [31:0] a;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        push_op(1'($urandom_range(0, 1)), {$urandom, $urandom}, 16'($urandom), $urandom,
                $urandom, $urandom);
        continue;
      end
      if (pick < 9) clock_s = clock_s + lim_age + $urandom_range(1, 50);
      else if (pick < 12) clock_s = clock_s - $urandom_range(0, 300);
      else clock_s = clock_s + $urandom_range(0, 3);
      idx = $urandom_range(0, 95);
      lp = lp_pool[idx];
      if ($urandom_range(0, 9) == 0) lp[$urandom_range(0, 47)] ^= 1'b1;
      pick = $urandom_range(0, 9);
      if (pick == 0) a = 32'd0;
      else if (pick == 1) a = 32'hFFFF_FFFF;
      else a = clock_s - $urandom_range(0, 60);
      push_op(1'($urandom_range(0, 1)), hash_pool[idx], lp[47:32], lp[31:0], clock_s, a);
    end
  endtask

  task automatic settle();
    while (op_queue.size() > 0 || status_queue.size() > 0 || in_valid) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_ENTRY_LIMIT) lim_entries = val[5:0];
    else lim_age = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < GENS; i++) begin
      gen_count[i] = 0;
      gen_created[i] = '0;
      gen_last[i] = '0;
    end
    for (int i = 0; i < 96; i++) begin
      hash_pool[i] = {$urandom, $urandom};
      lp_pool[i] = {16'($urandom_range(0, 40)), $urandom};
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, refresh, overwrite, hits, misses, stale and clock behind.
    push_op(MODE_INSERT, '0, '0, '0, 32'd1000, '0);
    push_op(MODE_INSERT, '1, '1, '1, 32'd1001, '0);
    push_op(MODE_LOOKUP, '0, '0, '0, '0, 32'd0);
    push_op(MODE_LOOKUP, '1, '1, '1, '0, 32'd1001);
    push_op(MODE_LOOKUP, '1, '1, '1, '0, 32'hFFFF_FFFF);
    push_op(MODE_LOOKUP, '1, '1, 32'hFFFF_FFFE, '0, 32'd0);
    push_op(MODE_LOOKUP, 64'h1234, 16'd4, 32'h11, '0, 32'd0);
    push_op(MODE_INSERT, '1, '1, '1, 32'd1010, '0);
    push_op(MODE_INSERT, '1, 16'd3, 32'h00616263, 32'd1020, '0);
    push_op(MODE_LOOKUP, '1, 16'd3, 32'h00616263, '0, 32'd1015);
    push_op(MODE_LOOKUP, '1, '1, '1, '0, 32'd0);
    push_op(MODE_INSERT, 64'h55, 16'd2, 32'h4142, 32'd200000, '0);
    push_op(MODE_INSERT, 64'h66, 16'd1, 32'h41, 32'd5, '0);
    push_op(MODE_LOOKUP, '0, '0, '0, '0, 32'd1000);
    push_op(MODE_LOOKUP, 64'h66, 16'd1, 32'h41, '0, 32'd5);
    push_op(MODE_INSERT, 64'h77, 16'd1, 32'h42, 32'hFFFF_FFFF, '0);
    push_op(MODE_LOOKUP, 64'h77, 16'd1, 32'h42, '0, 32'hFFFF_FFFF);
    push_op(MODE_INSERT, 64'h88, 16'd0, 32'h0, 32'd0, '1);
    clock_s = 32'd300000;
    push_random(140);
    settle();

    write_reg(REG_ENTRY_LIMIT, 32'd0);
    write_reg(REG_MAX_AGE, 32'd0);
    push_random(150);
    settle();

    write_reg(REG_ENTRY_LIMIT, 32'd5);
    write_reg(REG_MAX_AGE, 32'd100);
    push_random(150);
    settle();

    // Fill the active generation to the brim with distinct keys, no idling.
    idle_on = 1'b0;
    write_reg(REG_ENTRY_LIMIT, 32'd63);
    write_reg(REG_MAX_AGE, 32'hFFFF_FFFF);
    for (int i = 0; i < 70; i++)
      push_op(MODE_INSERT, {$urandom, $urandom}, 16'($urandom), $urandom, clock_s, '0);
    push_random(80);
    settle();

    idle_on = 1'b1;
    write_reg(REG_ENTRY_LIMIT, 32'd20);
    write_reg(REG_MAX_AGE, 32'd1000);
    push_random(150);
    settle();

    $display("Covered %0d results: %0d lookup hits, %0d refreshes, %0d rotations, %0d full",
             n_checked, n_hits, n_refresh, n_rotate, n_full);
    if (errors == 0) begin
      $display("[rotating_generation_key_set_top] OK");
    end else begin
      $display("[rotating_generation_key_set_top] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
